// ===== rtl/spcr_pkg.sv =====
// ----------------------------------------------------------------------------
// spcr_pkg
// Types and constants shared by the skin pixel classify/recolor core.
// ----------------------------------------------------------------------------
`default_nettype none

package spcr_pkg;

  localparam int unsigned GAIN_W  = 9;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned NSTAGE  = 7;
  localparam int unsigned LINE_W  = 28;

  // register map, word index = paddr[3:2]
  localparam logic [1:0] REG_GAIN_BLUE  = 2'd0;
  localparam logic [1:0] REG_GAIN_GREEN = 2'd1;
  localparam logic [1:0] REG_GAIN_RED   = 2'd2;

  // reciprocal table numerators: 255*4096 and 30*4096
  localparam int unsigned SAT_NUM = 1044480;
  localparam int unsigned HUE_NUM = 122880;

  // BT.601 luma weights, Q14
  localparam int unsigned Y_R   = 4899;
  localparam int unsigned Y_G   = 9617;
  localparam int unsigned Y_B   = 1868;
  localparam int unsigned Y_RND = 8192;

  // rule one limits; 0.23..0.68 of 255 in whole steps
  localparam int unsigned HUE_MAX = 50;
  localparam int unsigned SAT_MIN = 59;
  localparam int unsigned SAT_MAX = 173;

  // rule two limits
  localparam int unsigned R_MIN   = 95;
  localparam int unsigned G_MIN   = 40;
  localparam int unsigned B_MIN   = 20;
  localparam int unsigned RG_MIN  = 15;
  localparam int unsigned CR_MIN  = 135;
  localparam int unsigned CB_MIN  = 85;
  localparam int unsigned Y_MIN   = 80;

  // Cr-vs-Cb boundaries in Q16
  localparam int unsigned L1_K = 103953;
  localparam int unsigned L1_C = 1310720;
  localparam int unsigned L2_K = 22597;
  localparam int unsigned L2_C = 4994295;
  localparam int unsigned L3_K = 299185;
  localparam int unsigned L3_C = 15372465;
  localparam int unsigned L4_K = 75366;
  localparam int unsigned L4_C = 19775488;
  localparam int unsigned L5_K = 149796;
  localparam int unsigned L5_C = 28367258;

  typedef struct packed {
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       is_skin;
  } pix_out_t;

  // per-pixel data riding alongside the color math
  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [16:0] prod_b;
    logic [16:0] prod_g;
    logic [16:0] prod_r;
    logic        rgb_ok;
    logic        r_gt_g;
  } side_t;

endpackage

`default_nettype wire

// ===== rtl/skin_pixel_classify_recolor_core.sv =====
// ----------------------------------------------------------------------------
// skin_pixel_classify_recolor_core
// Per-pixel skin classifier (HSV and YCrCb rules) with Q8 gain recolor.
// ----------------------------------------------------------------------------
// Takes one BGR pixel per clock unless the output stalls, and returns one
// result per pixel, in order. A stall on the output freezes the whole
// seven-stage pipeline, so in_ready_o follows out_ready_i whenever the output
// register is full. Gains are written over the APB port at 0x0 (blue),
// 0x4 (green) and 0x8 (red), reset to 0, and should be changed only while
// no pixel is in flight.
`default_nettype none

module skin_pixel_classify_recolor_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,

  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire spcr_pkg::pix_in_t in_data_i,

  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      spcr_pkg::pix_out_t out_data_o,

  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [spcr_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [spcr_pkg::DATA_W-1:0]   pwdata,
  output      logic [spcr_pkg::DATA_W-1:0]   prdata,
  output      logic                          pready
);

  // ---------------- configuration ----------------
  logic [spcr_pkg::GAIN_W-1:0] gain_b_q, gain_g_q, gain_r_q;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_b_q <= '0;
      gain_g_q <= '0;
      gain_r_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        spcr_pkg::REG_GAIN_BLUE:  gain_b_q <= pwdata[spcr_pkg::GAIN_W-1:0];
        spcr_pkg::REG_GAIN_GREEN: gain_g_q <= pwdata[spcr_pkg::GAIN_W-1:0];
        spcr_pkg::REG_GAIN_RED:   gain_r_q <= pwdata[spcr_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      spcr_pkg::REG_GAIN_BLUE:  prdata = {{(spcr_pkg::DATA_W-spcr_pkg::GAIN_W){1'b0}}, gain_b_q};
      spcr_pkg::REG_GAIN_GREEN: prdata = {{(spcr_pkg::DATA_W-spcr_pkg::GAIN_W){1'b0}}, gain_g_q};
      spcr_pkg::REG_GAIN_RED:   prdata = {{(spcr_pkg::DATA_W-spcr_pkg::GAIN_W){1'b0}}, gain_r_q};
      default:                  prdata = '0;
    endcase
  end

  // ---------------- reciprocal tables ----------------
  logic [19:0] sat_tab [256];
  logic [16:0] hue_tab [256];

  assign sat_tab[0] = '0;
  assign hue_tab[0] = '0;
  for (genvar gi = 1; gi < 256; gi++) begin : g_tab
    localparam int unsigned SatR = (spcr_pkg::SAT_NUM + gi / 2) / gi;
    localparam int unsigned HueR = (spcr_pkg::HUE_NUM + gi / 2) / gi;
    assign sat_tab[gi] = 20'(SatR);
    assign hue_tab[gi] = 17'(HueR);
  end

  // ---------------- pipeline control ----------------
  logic [spcr_pkg::NSTAGE-1:0] vld_q;
  logic                        adv;

  assign adv        = !vld_q[spcr_pkg::NSTAGE-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[spcr_pkg::NSTAGE-2:0], in_valid_i};
    end
  end

  // ---------------- stage 1: input capture ----------------
  spcr_pkg::pix_in_t s1_pix_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pix_q <= in_data_i;
    end
  end

  // ---------------- stage 2: max/min, hue numerator, luma sum ----------------
  logic [7:0]         b1, g1, r1, vmax2_d, vmin2_d, diff2_d, absrg;
  logic signed [11:0] bs, gs, rs, ds, num2_d;
  logic [21:0]        ysum2_d;
  spcr_pkg::side_t    side2_d;

  logic [7:0]         vmax2_q, diff2_q;
  logic signed [11:0] num2_q;
  logic [21:0]        ysum2_q;
  spcr_pkg::side_t    side2_q;

  always_comb begin
    b1 = s1_pix_q.blue_in;
    g1 = s1_pix_q.green_in;
    r1 = s1_pix_q.red_in;
    vmax2_d = (b1 > g1) ? b1 : g1;
    vmax2_d = (r1 > vmax2_d) ? r1 : vmax2_d;
    vmin2_d = (b1 < g1) ? b1 : g1;
    vmin2_d = (r1 < vmin2_d) ? r1 : vmin2_d;
    diff2_d = vmax2_d - vmin2_d;
    bs = $signed({4'b0, b1});
    gs = $signed({4'b0, g1});
    rs = $signed({4'b0, r1});
    ds = $signed({4'b0, diff2_d});
    priority if (vmax2_d == r1) begin
      num2_d = gs - bs;
    end else if (vmax2_d == g1) begin
      num2_d = bs - rs + (ds <<< 1);
    end else begin
      num2_d = rs - gs + (ds <<< 2);
    end
    ysum2_d = 22'(spcr_pkg::Y_R * r1) + 22'(spcr_pkg::Y_G * g1)
            + 22'(spcr_pkg::Y_B * b1) + 22'(spcr_pkg::Y_RND);
    absrg = (r1 > g1) ? (r1 - g1) : (g1 - r1);
    side2_d.blue   = b1;
    side2_d.green  = g1;
    side2_d.red    = r1;
    side2_d.prod_b = {9'b0, b1} * {8'b0, gain_b_q};
    side2_d.prod_g = {9'b0, g1} * {8'b0, gain_g_q};
    side2_d.prod_r = {9'b0, r1} * {8'b0, gain_r_q};
    side2_d.rgb_ok = (r1 > 8'(spcr_pkg::R_MIN)) && (g1 > 8'(spcr_pkg::G_MIN))
                  && (b1 > 8'(spcr_pkg::B_MIN)) && (r1 > b1)
                  && (absrg > 8'(spcr_pkg::RG_MIN));
    side2_d.r_gt_g = r1 > g1;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vmax2_q <= vmax2_d;
      diff2_q <= diff2_d;
      num2_q  <= num2_d;
      ysum2_q <= ysum2_d;
      side2_q <= side2_d;
    end
  end

  // ---------------- stage 3: reciprocals, luma ----------------
  logic [19:0]        rsat3_q;
  logic [16:0]        rhue3_q;
  logic [7:0]         y3_q, diff3_q;
  logic signed [11:0] num3_q;
  spcr_pkg::side_t    side3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsat3_q <= sat_tab[vmax2_q];
      rhue3_q <= hue_tab[diff2_q];
      y3_q    <= ysum2_q[21:14];
      diff3_q <= diff2_q;
      num3_q  <= num2_q;
      side3_q <= side2_q;
    end
  end

  // ---------------- stage 4: products ----------------
  logic [27:0]        sprod4_d, sprod4_q;
  logic signed [29:0] hprod4_d, hprod4_q;
  logic signed [9:0]  ry, by;
  logic signed [24:0] cr4_d, cb4_d, cr4_q, cb4_q;
  logic               yok4_q;
  spcr_pkg::side_t    side4_q;

  always_comb begin
    sprod4_d = {20'b0, diff3_q} * {8'b0, rsat3_q};
    hprod4_d = 30'(num3_q) * 30'($signed({1'b0, rhue3_q}));
    ry       = $signed({2'b0, side3_q.red})  - $signed({2'b0, y3_q});
    by       = $signed({2'b0, side3_q.blue}) - $signed({2'b0, y3_q});
    cr4_d    = 25'(ry) * 25'sd11682 + 25'sd2105344;
    cb4_d    = 25'(by) * 25'sd9241  + 25'sd2105344;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sprod4_q <= sprod4_d;
      hprod4_q <= hprod4_d;
      cr4_q    <= cr4_d;
      cb4_q    <= cb4_d;
      yok4_q   <= y3_q > 8'(spcr_pkg::Y_MIN);
      side4_q  <= side3_q;
    end
  end

  // ---------------- stage 5: descale, rule one tests ----------------
  logic [27:0]        ssum;
  logic [15:0]        sval;
  logic signed [29:0] hsum;
  logic [7:0]         cr5_d, cb5_d, cr5_q, cb5_q;
  logic               hue5_q, sat5_q, yok5_q;
  spcr_pkg::side_t    side5_q;

  always_comb begin
    ssum = sprod4_q + 28'd2048;
    sval = ssum[27:12];
    hsum = hprod4_q + 30'sd2048;
    if (cr4_q[24]) begin
      cr5_d = '0;
    end else if (cr4_q[23:22] != 2'b00) begin
      cr5_d = 8'hFF;
    end else begin
      cr5_d = cr4_q[21:14];
    end
    if (cb4_q[24]) begin
      cb5_d = '0;
    end else if (cb4_q[23:22] != 2'b00) begin
      cb5_d = 8'hFF;
    end else begin
      cb5_d = cb4_q[21:14];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // negative hue wraps to 150..179, never within rule one
      hue5_q  <= !hsum[29] && (hsum[29:12] <= 18'(spcr_pkg::HUE_MAX));
      sat5_q  <= (sval >= 16'(spcr_pkg::SAT_MIN)) && (sval <= 16'(spcr_pkg::SAT_MAX));
      cr5_q   <= cr5_d;
      cb5_q   <= cb5_d;
      yok5_q  <= yok4_q;
      side5_q <= side4_q;
    end
  end

  // ---------------- stage 6: line terms ----------------
  logic [spcr_pkg::LINE_W-1:0] crq6_d;
  logic [spcr_pkg::LINE_W-1:0] l1_q, l2_q, l3_q, l4_q, l5_q, crq6_q;
  logic                        rule1_6_q, pre2_6_q;
  spcr_pkg::side_t             side6_q;

  assign crq6_d = {4'b0, cr5_q, 16'b0};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      crq6_q    <= crq6_d;
      l1_q      <= 28'(spcr_pkg::L1_K * cb5_q) + 28'(spcr_pkg::L1_C);
      l2_q      <= 28'(spcr_pkg::L2_K * cb5_q) + 28'(spcr_pkg::L2_C);
      l3_q      <= crq6_d + 28'(spcr_pkg::L3_K * cb5_q);
      l4_q      <= crq6_d + 28'(spcr_pkg::L4_K * cb5_q);
      l5_q      <= crq6_d + 28'(spcr_pkg::L5_K * cb5_q);
      rule1_6_q <= side5_q.rgb_ok && side5_q.r_gt_g && hue5_q && sat5_q;
      pre2_6_q  <= side5_q.rgb_ok && (cr5_q > 8'(spcr_pkg::CR_MIN))
                && (cb5_q > 8'(spcr_pkg::CB_MIN)) && yok5_q;
      side6_q   <= side5_q;
    end
  end

  // ---------------- stage 7: decision, recolor, output register ----------------
  logic               rule2, skin;
  spcr_pkg::pix_out_t out_d, out_q;

  always_comb begin
    rule2 = pre2_6_q
         && (crq6_q <= l1_q)
         && (crq6_q >= l2_q)
         && (l3_q >= 28'(spcr_pkg::L3_C))
         && (l4_q <= 28'(spcr_pkg::L4_C))
         && (l5_q <= 28'(spcr_pkg::L5_C));
    skin = rule1_6_q || rule2;
    if (skin) begin
      out_d.blue_out  = side6_q.prod_b[16] ? 8'hFF : side6_q.prod_b[15:8];
      out_d.green_out = side6_q.prod_g[16] ? 8'hFF : side6_q.prod_g[15:8];
      out_d.red_out   = side6_q.prod_r[16] ? 8'hFF : side6_q.prod_r[15:8];
    end else begin
      out_d.blue_out  = side6_q.blue;
      out_d.green_out = side6_q.green;
      out_d.red_out   = side6_q.red;
    end
    out_d.is_skin = skin;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[spcr_pkg::NSTAGE-1];
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  ap_ready_only_low_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !in_ready_o |-> out_valid_o
  ) else $error("input stalled while output register empty");

  ap_accept_enters_pipe: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_valid_i && in_ready_o |=> vld_q[0]
  ) else $error("accepted transaction not captured in first stage");

  ap_stall_freezes_pipe: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !in_ready_o |=> $stable(vld_q)
  ) else $error("pipeline moved during output stall");
`endif

endmodule

`default_nettype wire
